// File: hw/rtl/psla_pkg.sv
package psla_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned LaneW     = 6;
  localparam int unsigned WordW     = 32;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned OpW       = 3;
  localparam int unsigned InDataW   = 200;
  localparam int unsigned OutDataW  = 32;
  localparam int unsigned FlagLsb   = 28;
  localparam int unsigned TopLaneLsb = 18;

  // Bit positions of the input fields inside s_axis_tdata.
  localparam int unsigned WordALsb  = 0;
  localparam int unsigned WordBLsb  = 32;
  localparam int unsigned ShiftLsb  = 64;
  localparam int unsigned LaneValLsb = 69;

  typedef enum logic [OpW-1:0] {
    OP_PACK = 3'd0,
    OP_ADD  = 3'd1,
    OP_SHL  = 3'd2,
    OP_SHR  = 3'd3,
    OP_SAR  = 3'd4
  } op_e;

  typedef struct packed {
    logic             flag;
    logic [LaneW-1:0] val;
  } lane_res_t;

  // Lowest bit of lane i inside a packed word.
  function automatic int unsigned lane_lsb(input int unsigned idx);
    lane_lsb = TopLaneLsb - LaneW * idx;
  endfunction

endpackage

// File: hw/rtl/psla_lane.sv
module psla_lane
  import psla_pkg::*;
(
  input  op_e               opcode_i,
  input  logic [LaneW-1:0]  lane_a_i,
  input  logic [LaneW-1:0]  lane_b_i,
  input  logic [ShiftW-1:0] shift_amount_i,
  input  logic signed [WordW-1:0] lane_value_i,
  output lane_res_t         res_o
);

  logic [LaneW:0] sum;
  logic           big_shift;

  assign sum       = {lane_a_i[LaneW-1], lane_a_i} + {lane_b_i[LaneW-1], lane_b_i};
  assign big_shift = (shift_amount_i >= ShiftW'(LaneW));

  always_comb begin
    res_o = '0;
    unique case (opcode_i)
      OP_PACK: begin
        res_o.val  = lane_value_i[LaneW-1:0];
        // out of range unless the bits above the lane all repeat its sign
        res_o.flag = !((&lane_value_i[WordW-1:LaneW-1]) ||
                       (~|lane_value_i[WordW-1:LaneW-1]));
      end
      OP_ADD: begin
        res_o.val  = sum[LaneW-1:0];
        res_o.flag = sum[LaneW] ^ sum[LaneW-1];
      end
      OP_SHL: begin
        res_o.val = big_shift ? '0 : LaneW'(lane_a_i << shift_amount_i);
      end
      OP_SHR: begin
        res_o.val = big_shift ? '0 : LaneW'(lane_a_i >> shift_amount_i);
      end
      OP_SAR: begin
        res_o.val = big_shift ? {LaneW{lane_a_i[LaneW-1]}}
                              : LaneW'($signed(lane_a_i) >>> shift_amount_i);
      end
      default: res_o = '0;
    endcase
  end

endmodule

// File: hw/rtl/psla_merge.sv
module psla_merge
  import psla_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lane_res_t            lanes_i [NumLanes],
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutDataW-1:0]  out_data_o
);

  logic                valid_q, valid_d;
  logic [OutDataW-1:0] data_q, data_d, word;
  logic                take;

  // Place each lane value and its flag into the result word.
  always_comb begin
    word = '0;
    for (int unsigned i = 0; i < NumLanes; i++) begin
      word[lane_lsb(i) +: LaneW]        = lanes_i[i].val;
      word[OutDataW-1-i]                = lanes_i[i].flag;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (take) begin
      valid_d = 1'b1;
      data_d  = word;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> valid_q)
    else $error("accepted request did not fill the output register");

  a_gap_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (data_q[FlagLsb-1:TopLaneLsb+LaneW] == '0))
    else $error("bits between flags and lanes are not zero");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("new request taken while result is stalled");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!take && out_ready_i) |=> !valid_q)
    else $error("result not released after it was taken");

endmodule

// File: hw/rtl/packed_six_bit_lane_alu.sv
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid/tready/tdata/tuser       operands, opcode in tuser
// m_axis    out  tvalid/tready/tdata             packed result word
//
// One request per cycle while m_axis is not stalled: the four lanes compute from the
// input request and the merged word lands in a single output register.
// Throughput is bounded only by that output register; s_axis_tready is high
// whenever it is empty or being drained in the same cycle.
// Reset (rst_ni low, asynchronous) empties the output register.
// A stalled m_axis holds its word and blocks s_axis until it is taken.
module packed_six_bit_lane_alu
  import psla_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // word_a, word_b, shift_amount, lane_value_0..lane_value_3 (low to high),
  // zero fill above bit 196
  input  logic [InDataW-1:0]   s_axis_tdata,
  // opcode
  input  logic [OpW-1:0]       s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // result_word
  output logic [OutDataW-1:0]  m_axis_tdata
);

  op_e               opcode;
  logic [WordW-1:0]  word_a, word_b;
  logic [ShiftW-1:0] shift_amount;
  lane_res_t         lane_res [NumLanes];

  // Unpack the request; opcodes past the last member fall to the zero arm.
  assign opcode       = op_e'(s_axis_tuser);
  assign word_a       = s_axis_tdata[WordALsb +: WordW];
  assign word_b       = s_axis_tdata[WordBLsb +: WordW];
  assign shift_amount = s_axis_tdata[ShiftLsb +: ShiftW];

  // One lane unit per sub-word, all working on the same request.
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    psla_lane u_lane (
      .opcode_i       (opcode),
      .lane_a_i       (word_a[lane_lsb(g) +: LaneW]),
      .lane_b_i       (word_b[lane_lsb(g) +: LaneW]),
      .shift_amount_i (shift_amount),
      .lane_value_i   ($signed(s_axis_tdata[LaneValLsb + WordW*g +: WordW])),
      .res_o          (lane_res[g])
    );
  end

  // Merge lane results and hold the word until the sink takes it.
  psla_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .lanes_i     (lane_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: verif/tb_packed_six_bit_lane_alu.sv
`timescale 1ns / 100ps

module tb_packed_six_bit_lane_alu;
  import psla_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 434;
  localparam int unsigned ReportLimit = 10;

  // One ALU request as the testbench sees it, before packing onto the bus.
  typedef struct packed {
    logic [OpW-1:0]                     op;
    logic [WordW-1:0]                   word_a;
    logic [WordW-1:0]                   word_b;
    logic [ShiftW-1:0]                  shamt;
    logic [NumLanes-1:0][WordW-1:0]     lane_val;
  } alu_req_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // word_a, word_b, shift_amount, lane_value_0..lane_value_3 (low to high),
  // zero fill above bit 196
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  // opcode
  logic [OpW-1:0]      s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // result_word
  logic [OutDataW-1:0] m_axis_tdata;

  alu_req_t         alu_req_q[$];      // requests waiting for the driver
  logic [WordW-1:0] result_word_q[$];  // predicted result words, oldest first
  alu_req_t         drv_req;           // request currently on s_axis

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_accepted    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned hold_at       = 0;
  int unsigned hold_left     = 0;
  logic        hold_arm      = 1'b0;
  logic        hold_done     = 1'b0;

  packed_six_bit_lane_alu u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Compute the packed result word of one request, lane by lane.
  function automatic logic [WordW-1:0] predict_result_word(alu_req_t r);
    logic [WordW-1:0]        res;
    logic [LaneW-1:0]        la;
    logic [LaneW-1:0]        lb;
    logic [LaneW-1:0]        lane;
    logic signed [LaneW:0]   sum;
    logic signed [WordW-1:0] v;
    int unsigned             lsb;
    res = '0;
    for (int i = 0; i < NumLanes; i++) begin
      lsb  = TopLaneLsb - LaneW * i;
      la   = r.word_a[lsb +: LaneW];
      lb   = r.word_b[lsb +: LaneW];
      lane = '0;
      case (r.op)
        OP_PACK: begin
          v    = r.lane_val[i];
          lane = v[LaneW-1:0];
          if (v < -32 || v > 31) res[WordW-1-i] = 1'b1;
        end
        OP_ADD: begin
          sum  = $signed({la[LaneW-1], la}) + $signed({lb[LaneW-1], lb});
          lane = sum[LaneW-1:0];
          if (sum < -32 || sum > 31) res[WordW-1-i] = 1'b1;
        end
        OP_SHL: begin
          if (r.shamt < LaneW) lane = la << r.shamt;
        end
        OP_SHR: begin
          if (r.shamt < LaneW) lane = la >> r.shamt;
        end
        OP_SAR: begin
          // counts of a full lane or more leave nothing but the sign
          if (r.shamt >= LaneW) lane = {LaneW{la[LaneW-1]}};
          else lane = $signed(la) >>> r.shamt;
        end
        default: ;
      endcase
      res[lsb +: LaneW] = lane;
    end
    return res;
  endfunction

  // Build a packed word: lane 0 in the high lane slot, junk allowed on top.
  function automatic logic [WordW-1:0] mk_word(logic [7:0] top, logic [LaneW-1:0] l0,
                                               logic [LaneW-1:0] l1, logic [LaneW-1:0] l2,
                                               logic [LaneW-1:0] l3);
    return {top, l0, l1, l2, l3};
  endfunction

  // Favor the lane extremes, which is where the flags and fills change.
  function automatic logic [LaneW-1:0] pick_lane();
    case ($urandom_range(7))
      0: return 6'h20;
      1: return 6'h1F;
      2: return 6'h00;
      3: return 6'h3F;
      4: return 6'h21;
      default: return LaneW'($urandom_range(63));
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    if ($urandom_range(3) == 0) return $urandom();
    return mk_word(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom()),
                   pick_lane(), pick_lane(), pick_lane(), pick_lane());
  endfunction

  // Pack values: mostly close to the -32..31 window, sometimes anything.
  function automatic int pick_lane_val();
    case ($urandom_range(7))
      0: return int'($urandom());
      1: return 31;
      2: return -32;
      3: return 32;
      4: return -33;
      5: return int'($urandom_range(63)) - 32;
      default: return int'($urandom_range(127)) - 64;
    endcase
  endfunction

  function automatic logic [ShiftW-1:0] pick_shamt();
    if ($urandom_range(4) == 0) return ShiftW'($urandom_range(31));
    return ShiftW'($urandom_range(7));
  endfunction

  task automatic add_req(input logic [OpW-1:0] op, input logic [WordW-1:0] a,
                         input logic [WordW-1:0] b, input logic [ShiftW-1:0] n,
                         input int v0, input int v1, input int v2, input int v3);
    alu_req_t r;
    r.op          = op;
    r.word_a      = a;
    r.word_b      = b;
    r.shamt       = n;
    r.lane_val[0] = v0;
    r.lane_val[1] = v1;
    r.lane_val[2] = v2;
    r.lane_val[3] = v3;
    alu_req_q.push_back(r);
  endtask

  task automatic add_random_reqs(input int unsigned count);
    logic [OpW-1:0] op;
    for (int unsigned k = 0; k < count; k++) begin
      // now and then an unused opcode, which must come back as zero
      if ($urandom_range(24) == 0) op = OpW'($urandom_range(7, int'(OP_SAR) + 1));
      else op = OpW'($urandom_range(int'(OP_SAR)));
      add_req(op, pick_word(), pick_word(), pick_shamt(),
              pick_lane_val(), pick_lane_val(), pick_lane_val(), pick_lane_val());
    end
  endtask

  // Hold the sender until every queued request is through and answered.
  task automatic drain_all();
    while (alu_req_q.size() != 0 || s_axis_tvalid || result_word_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input logic [WordW-1:0] want,
                               input logic [WordW-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= ReportLimit)
      $display("%0t: %s result_word expected %08h actual %08h", $realtime, what, want, got);
  endtask

  // Driver: offer the next request whenever the bus is free or just moved one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_word_q.push_back(predict_result_word(drv_req));
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (alu_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = alu_req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= drv_req.op;
          s_axis_tdata  <= {3'b000, drv_req.lane_val[3], drv_req.lane_val[2],
                            drv_req.lane_val[1], drv_req.lane_val[0], drv_req.shamt,
                            drv_req.word_b, drv_req.word_a};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off once armed so the
  // output register fills and the input side has to stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_arm && !hold_done && n_accepted >= hold_at) begin
      hold_left     <= HoldCycles;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: every result moved must match the oldest prediction.
  always @(posedge clk_i) begin
    logic [WordW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_word_q.size() == 0) begin
        note_mismatch("unexpected", '0, m_axis_tdata);
      end else begin
        want = result_word_q.pop_front();
        if (m_axis_tdata !== want) note_mismatch("mismatch", want, m_axis_tdata);
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int shift_list[5];
    shift_list = '{0, 1, 5, 6, 31};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Phase one: sender rarely idles, receiver mostly stalls.
    send_idle_pct = 6;
    recv_idle_pct = 73;

    // Pack: in-range extremes, just outside, and the 32-bit extremes.
    add_req(OP_PACK, '1, '1, '1, 0, -1, 31, -32);
    add_req(OP_PACK, '0, '0, '0, 32, -33, 2147483647, -2147483648);
    add_req(OP_PACK, $urandom(), $urandom(), 5'h15, 63, -64, 64, 1000);
    // Add: overflow both ways, borderline sums, junk in the flag and pad bits.
    add_req(OP_ADD, mk_word(8'hFF, 6'h1F, 6'h20, 6'h3F, 6'h00),
            mk_word(8'h00, 6'h01, 6'h3F, 6'h20, 6'h00), '1, -1, -1, -1, -1);
    add_req(OP_ADD, mk_word(8'h0F, 6'h1F, 6'h20, 6'h1F, 6'h20),
            mk_word(8'hF0, 6'h1F, 6'h20, 6'h20, 6'h1F), '0, 0, 0, 0, 0);
    add_req(OP_ADD, mk_word(8'hA5, 6'h10, 6'h30, 6'h0F, 6'h3F),
            mk_word(8'h5A, 6'h0F, 6'h30, 6'h10, 6'h21), 5'h0A, 0, 0, 0, 0);
    // Shifts: counts below, at and beyond the lane width, both signs.
    for (int k = int'(OP_SHL); k <= int'(OP_SAR); k++)
      for (int s = 0; s < 5; s++)
        add_req(OpW'(k), mk_word(8'hFF, 6'h3F, 6'h20, 6'h1F, 6'h21), $urandom(),
                ShiftW'(shift_list[s]), 0, 0, 0, 0);
    // Unused opcodes with busy operands: the result must be zero.
    for (int k = int'(OP_SAR) + 1; k < 8; k++)
      add_req(OpW'(k), '1, '1, '1, -1, 2147483647, -2147483648, 32);

    add_random_reqs(PhaseItems);
    drain_all();

    // Phase two: the other way round.
    send_idle_pct = 73;
    recv_idle_pct = 6;
    add_random_reqs(PhaseItems);
    drain_all();

    // Phase three: full rate, with the long receiver hold-off part way in.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_at       = n_accepted + 60;
    hold_arm      = 1'b1;
    add_random_reqs(PhaseItems);
    drain_all();

    // Let any straggler show up before the verdict.
    repeat (8) @(negedge clk_i);
    if (mismatch_cnt == 0 && result_word_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
